// ===== rtl/plu_pkg.sv =====
// plu_pkg: request and result types, register indexes and saturating
// Q4.28 arithmetic shared by the pixel lift and undistort core and its cells
// no dependencies
`default_nettype none

package plu_pkg;

  localparam int FRAC_BITS = 28;
  localparam int DIV_STEPS = 31;
  localparam int PASS_STAGES = 8;
  localparam int NUM_W = 53;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
  } req_t;

  typedef struct packed {
    logic signed [31:0] ray_x;
    logic signed [31:0] ray_y;
  } res_t;

  typedef enum logic [3:0] {
    REG_FOCAL_X = 4'd0,
    REG_FOCAL_Y = 4'd1,
    REG_CENTER_X = 4'd2,
    REG_CENTER_Y = 4'd3,
    REG_RADIAL_K1 = 4'd4,
    REG_RADIAL_K2 = 4'd5,
    REG_TANG_P1 = 4'd6,
    REG_TANG_P2 = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic neg;
    logic ovf;
    logic [NUM_W-1:0] rem;
    logic [DIV_STEPS-1:0] quo;
  } div_part_t;

  typedef struct packed {
    logic valid;
    div_part_t px;
    div_part_t py;
  } div_t;

  typedef struct packed {
    logic valid;
    logic signed [31:0] xd;
    logic signed [31:0] yd;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pass_t;

  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    logic signed [31:0] r;
    if ((&v[65:31]) || !(|v[65:31])) begin
      r = v[31:0];
    end else if (v[65]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  function automatic logic signed [65:0] ext66(input logic signed [31:0] a);
    return signed'({{34{a[31]}}, a});
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat66(ext66(a) + ext66(b));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat66(ext66(a) - ext66(b));
  endfunction

  function automatic logic signed [31:0] qdbl(input logic signed [31:0] a);
    return sat66(ext66(a) + ext66(a));
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [65:0] t;
    p = a * b;
    t = signed'({{2{p[63]}}, p}) + (66'sd1 <<< (FRAC_BITS - 1));
    return sat66(t >>> FRAC_BITS);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/plu_div_cell.sv =====
// plu_div_cell: one quotient bit of the pipelined restoring divider that
// normalizes both pixel coordinates; uses plu_pkg
`default_nettype none

module plu_div_cell import plu_pkg::*; #(
  parameter int BIT = 0
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [23:0] fx,
  input  wire logic [23:0] fy,
  input  wire div_t        din,
  output div_t             dout
);

  div_t step;

  function automatic div_part_t bit_step(input div_part_t p, input logic [23:0] f);
    div_part_t o;
    logic [NUM_W+1:0] dv;
    o = p;
    dv = {{(NUM_W-22){1'b0}}, f} << BIT;
    if ({2'b00, p.rem} >= dv) begin
      o.rem = p.rem - dv[NUM_W-1:0];
      o.quo[BIT] = 1'b1;
    end
    return o;
  endfunction

  always_comb begin
    step.valid = din.valid;
    step.px = bit_step(din.px, fx);
    step.py = bit_step(din.py, fy);
  end

  always_ff @(posedge clk) begin
    dout.px <= step.px;
    dout.py <= step.py;
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= step.valid;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/plu_pass_cell.sv =====
// plu_pass_cell: one refinement pass, estimate = distorted - delta(estimate),
// as an eight stage pipeline; uses plu_pkg
`default_nettype none

module plu_pass_cell import plu_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic signed [31:0] k1,
  input  wire logic signed [31:0] k2,
  input  wire logic signed [31:0] p1,
  input  wire logic signed [31:0] p2,
  input  wire pass_t              din,
  output pass_t                   dout
);

  logic [PASS_STAGES-2:0] v;
  logic signed [31:0] xd [PASS_STAGES-1];
  logic signed [31:0] yd [PASS_STAGES-1];
  logic signed [31:0] x [PASS_STAGES-3];
  logic signed [31:0] y [PASS_STAGES-3];

  logic signed [31:0] x2, y2, xy;
  logic signed [31:0] r2, x2d, y2d, p1xy, p2xy;
  logic signed [31:0] ax, ay, r4, k1r2_3, p1xy2_3, p2xy2_3;
  logic signed [31:0] k2r4, tx4, ty4, k1r2_4, p1xy2_4, p2xy2_4;
  logic signed [31:0] rad, tx5, ty5, p1xy2_5, p2xy2_5;
  logic signed [31:0] xr, yr, tx6, ty6, p1xy2_6, p2xy2_6;
  logic signed [31:0] dx, dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[PASS_STAGES-3:0], din.valid};
    end
  end

  always_ff @(posedge clk) begin
    xd[0] <= din.xd;
    yd[0] <= din.yd;
    x[0] <= din.x;
    y[0] <= din.y;
    for (int i = 1; i < PASS_STAGES - 1; i++) begin
      xd[i] <= xd[i-1];
      yd[i] <= yd[i-1];
    end
    for (int i = 1; i < PASS_STAGES - 3; i++) begin
      x[i] <= x[i-1];
      y[i] <= y[i-1];
    end
    // squares and cross term
    x2 <= qmul(din.x, din.x);
    y2 <= qmul(din.y, din.y);
    xy <= qmul(din.x, din.y);
    // radius and tangential products
    r2 <= qadd(x2, y2);
    x2d <= qdbl(x2);
    y2d <= qdbl(y2);
    p1xy <= qmul(p1, xy);
    p2xy <= qmul(p2, xy);
    ax <= qadd(r2, x2d);
    ay <= qadd(r2, y2d);
    r4 <= qmul(r2, r2);
    k1r2_3 <= qmul(k1, r2);
    p1xy2_3 <= qdbl(p1xy);
    p2xy2_3 <= qdbl(p2xy);
    k2r4 <= qmul(k2, r4);
    tx4 <= qmul(p2, ax);
    ty4 <= qmul(p1, ay);
    k1r2_4 <= k1r2_3;
    p1xy2_4 <= p1xy2_3;
    p2xy2_4 <= p2xy2_3;
    rad <= qadd(k1r2_4, k2r4);
    tx5 <= tx4;
    ty5 <= ty4;
    p1xy2_5 <= p1xy2_4;
    p2xy2_5 <= p2xy2_4;
    xr <= qmul(x[PASS_STAGES-4], rad);
    yr <= qmul(y[PASS_STAGES-4], rad);
    tx6 <= tx5;
    ty6 <= ty5;
    p1xy2_6 <= p1xy2_5;
    p2xy2_6 <= p2xy2_5;
    dx <= qadd(qadd(xr, p1xy2_6), tx6);
    dy <= qadd(qadd(yr, p2xy2_6), ty6);
    dout.xd <= xd[PASS_STAGES-2];
    dout.yd <= yd[PASS_STAGES-2];
    dout.x <= qsub(xd[PASS_STAGES-2], dx);
    dout.y <= qsub(yd[PASS_STAGES-2], dy);
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= v[PASS_STAGES-2];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pixel_lift_undistort_core.sv =====
// pixel_lift_undistort_core: lifts a pixel to a normalized ray and removes
// radial and tangential lens distortion; uses plu_pkg, plu_div_cell, plu_pass_cell
//
//  channel   signals                                   dir  handshake
//  request   start, busy, pixel                        in   start & !busy
//  result    done, ray                                 out  strobe, one cycle
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in   valid & ready
//
// one request per cycle outside reset; each result passes from its request
// through the set-up register, the 31 stage divider, the finish register and
// REFINE_PASSES+1 eight stage pass cells. busy is high only during reset.
// results cannot be held off, so nothing stalls. config is taken every cycle
// and must only change while no request is in flight.
`default_nettype none

module pixel_lift_undistort_core import plu_pkg::*; #(
  parameter int REFINE_PASSES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        pixel,
  output logic             done,
  output res_t             ray,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int NUM_PASSES = REFINE_PASSES + 1;
  localparam int LATENCY = 2 + DIV_STEPS + PASS_STAGES * NUM_PASSES;

  logic [23:0] focal_x, focal_y, center_x, center_y;
  logic signed [31:0] radial_k1, radial_k2, tangential_p1, tangential_p2;
  logic [23:0] fx, fy;
  div_t div_chain [DIV_STEPS+1];
  pass_t pass_chain [NUM_PASSES+1];

  assign busy = rst;
  assign cfg_ready = 1'b1;
  assign fx = (focal_x == 24'd0) ? 24'd1 : focal_x;
  assign fy = (focal_y == 24'd0) ? 24'd1 : focal_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x <= 24'd131072;
      focal_y <= 24'd131072;
      center_x <= 24'd81920;
      center_y <= 24'd61440;
      radial_k1 <= '0;
      radial_k2 <= '0;
      tangential_p1 <= '0;
      tangential_p2 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FOCAL_X: focal_x <= cfg_data[23:0];
        REG_FOCAL_Y: focal_y <= cfg_data[23:0];
        REG_CENTER_X: center_x <= cfg_data[23:0];
        REG_CENTER_Y: center_y <= cfg_data[23:0];
        REG_RADIAL_K1: radial_k1 <= cfg_data;
        REG_RADIAL_K2: radial_k2 <= cfg_data;
        REG_TANG_P1: tangential_p1 <= cfg_data;
        REG_TANG_P2: tangential_p2 <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic div_part_t norm_setup(input logic [15:0] pix,
                                           input logic [23:0] f,
                                           input logic [23:0] c);
    div_part_t o;
    logic signed [24:0] diff;
    logic [24:0] mag;
    logic [NUM_W-1:0] num;
    diff = signed'({5'b0, pix, 4'b0}) - signed'({1'b0, c});
    mag = diff[24] ? 25'(-diff) : 25'(diff);
    num = {mag, 28'b0} + {30'b0, f[23:1]};
    o.neg = diff[24];
    o.ovf = ({2'b00, num} >= {f, 31'b0});
    o.rem = num;
    o.quo = '0;
    return o;
  endfunction

  function automatic logic signed [31:0] norm_finish(input div_part_t p);
    logic [31:0] qc;
    logic signed [65:0] m;
    qc = p.ovf ? 32'h8000_0000 : {1'b0, p.quo};
    m = signed'({34'b0, qc});
    return sat66(p.neg ? -m : m);
  endfunction

  // distorted point, divider set-up
  always_ff @(posedge clk) begin
    div_chain[0].px <= norm_setup(pixel.pixel_x, fx, center_x);
    div_chain[0].py <= norm_setup(pixel.pixel_y, fy, center_y);
    if (rst) begin
      div_chain[0].valid <= 1'b0;
    end else begin
      div_chain[0].valid <= start && !busy;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    plu_div_cell #(
      .BIT(DIV_STEPS - 1 - i)
    ) u_div (
      .clk (clk),
      .rst (rst),
      .fx  (fx),
      .fy  (fy),
      .din (div_chain[i]),
      .dout(div_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    pass_chain[0].xd <= norm_finish(div_chain[DIV_STEPS].px);
    pass_chain[0].yd <= norm_finish(div_chain[DIV_STEPS].py);
    pass_chain[0].x <= norm_finish(div_chain[DIV_STEPS].px);
    pass_chain[0].y <= norm_finish(div_chain[DIV_STEPS].py);
    if (rst) begin
      pass_chain[0].valid <= 1'b0;
    end else begin
      pass_chain[0].valid <= div_chain[DIV_STEPS].valid;
    end
  end

  for (genvar i = 0; i < NUM_PASSES; i++) begin : g_pass
    plu_pass_cell u_pass (
      .clk (clk),
      .rst (rst),
      .k1  (radial_k1),
      .k2  (radial_k2),
      .p1  (tangential_p1),
      .p2  (tangential_p2),
      .din (pass_chain[i]),
      .dout(pass_chain[i+1])
    );
  end

  assign done = pass_chain[NUM_PASSES].valid;
  assign ray = {pass_chain[NUM_PASSES].x, pass_chain[NUM_PASSES].y};

`ifndef NO_ASSERTIONS
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching request");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result right after reset");

  a_div_to_pass: assert property (@(posedge clk) disable iff (rst)
    div_chain[DIV_STEPS].valid |=> pass_chain[0].valid)
    else $error("divider output lost");
`endif

endmodule

`default_nettype wire
